// ===== design/tasc_pkg.sv =====
package tasc_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int CODE_WIDTH = 32;
    localparam int SQ_WIDTH   = 32;
    localparam int MS_WIDTH   = 16;
    localparam int ACC_WIDTH  = 16;
    localparam int FUNC_WIDTH = 2;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int IN_DATA_WIDTH  = 88;
    localparam int OUT_DATA_WIDTH = 16;

    typedef logic [TIME_WIDTH-1:0] time_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WARN  = 2'd1,
        ST_ALERT = 2'd2,
        ST_TRACK = 2'd3
    } stage_t;

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_RF    = 2'd1,
        FUNC_ACCEL = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_OWNER_CODE     = 3'd0,
        CFG_NETWORK_CODE   = 3'd1,
        CFG_CLEAR_CODE     = 3'd2,
        CFG_STILL_LOW_SQ   = 3'd3,
        CFG_STILL_HIGH_SQ  = 3'd4,
        CFG_WARNING_MS     = 3'd5,
        CFG_BEEP_HALF_MS   = 3'd6,
        CFG_MOTION_HOLD_MS = 3'd7
    } cfg_idx_t;

    localparam logic [SQ_WIDTH-1:0] STILL_LOW_SQ_RST  = 32'd60840000;
    localparam logic [SQ_WIDTH-1:0] STILL_HIGH_SQ_RST = 32'd139240000;
    localparam logic [MS_WIDTH-1:0] WARNING_MS_RST     = 16'd10000;
    localparam logic [MS_WIDTH-1:0] BEEP_HALF_MS_RST   = 16'd500;
    localparam logic [MS_WIDTH-1:0] MOTION_HOLD_MS_RST = 16'd5000;

    // square of the magnitude of a signed sample; -32768 yields 2^30
    function automatic logic [SQ_WIDTH-1:0] sq_mag(input logic [ACC_WIDTH-1:0] a);
        logic [ACC_WIDTH-1:0] mag;
        mag = a[ACC_WIDTH-1] ? (~a + {{(ACC_WIDTH-1){1'b0}}, 1'b1}) : a;
        return {{(SQ_WIDTH-ACC_WIDTH){1'b0}}, mag} * {{(SQ_WIDTH-ACC_WIDTH){1'b0}}, mag};
    endfunction

endpackage

// ===== design/theft_alarm_stage_controller_core.sv =====
// Theft alarm stage controller core.
// Datapath: an accepted input word is held in the input register, then one combinational pass of
//   squares, band compare and stage logic loads the result register.
// Throughput: one word per cycle while downstream takes each result word.
// Reset (rst_n low, asynchronous): clock and time marks zero, stage idle, buzzer off,
//   owner absent, no motion, configuration registers back to their defaults.
module theft_alarm_stage_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // rf_code[31:0], rf_enabled[32], accel_x[48:33], accel_y[64:49], accel_z[80:65], zero[87:81]
    input  logic [tasc_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
    // func[1:0]
    input  logic [tasc_pkg::FUNC_WIDTH-1:0]      s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // alarm_stage[1:0], buzzer_on[2], owner_here[3], moving[4], network_request[5],
    // gps_on_request[6], gps_off_request[7], sms_request[8], zero[15:9]
    output logic [tasc_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tasc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [tasc_pkg::CODE_WIDTH-1:0]      cfg_data
);
    import tasc_pkg::*;

    // configuration registers
    logic [CODE_WIDTH-1:0] owner_code_reg;
    logic [CODE_WIDTH-1:0] network_code_reg;
    logic [CODE_WIDTH-1:0] clear_code_reg;
    logic [SQ_WIDTH-1:0]   still_low_sq_reg;
    logic [SQ_WIDTH-1:0]   still_high_sq_reg;
    logic [MS_WIDTH-1:0]   warning_ms_reg;
    logic [MS_WIDTH-1:0]   beep_half_ms_reg;
    logic [MS_WIDTH-1:0]   motion_hold_ms_reg;

    // input register
    logic                  in_valid_reg;
    logic [FUNC_WIDTH-1:0] func_reg;
    logic [CODE_WIDTH-1:0] rf_code_reg;
    logic                  rf_enabled_reg;
    logic [ACC_WIDTH-1:0]  accel_x_reg;
    logic [ACC_WIDTH-1:0]  accel_y_reg;
    logic [ACC_WIDTH-1:0]  accel_z_reg;

    // controller state
    time_t  now_reg,          now_next;
    time_t  stage_start_reg,  stage_start_next;
    time_t  last_toggle_reg,  last_toggle_next;
    time_t  motion_start_reg, motion_start_next;
    stage_t stage_reg,        stage_next;
    logic   buzzer_reg,       buzzer_next;
    logic   owner_reg,        owner_next;
    logic   motion_reg,       motion_next;

    // result register
    logic                      out_valid_reg;
    logic [OUT_DATA_WIDTH-1:0] out_data_reg, out_data_next;

    logic advance;
    logic fire;

    // the result slot frees when empty or when downstream takes the word
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_code_reg     <= '0;
            network_code_reg   <= '0;
            clear_code_reg     <= '0;
            still_low_sq_reg   <= STILL_LOW_SQ_RST;
            still_high_sq_reg  <= STILL_HIGH_SQ_RST;
            warning_ms_reg     <= WARNING_MS_RST;
            beep_half_ms_reg   <= BEEP_HALF_MS_RST;
            motion_hold_ms_reg <= MOTION_HOLD_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OWNER_CODE:     owner_code_reg     <= cfg_data;
                CFG_NETWORK_CODE:   network_code_reg   <= cfg_data;
                CFG_CLEAR_CODE:     clear_code_reg     <= cfg_data;
                CFG_STILL_LOW_SQ:   still_low_sq_reg   <= cfg_data;
                CFG_STILL_HIGH_SQ:  still_high_sq_reg  <= cfg_data;
                CFG_WARNING_MS:     warning_ms_reg     <= cfg_data[MS_WIDTH-1:0];
                CFG_BEEP_HALF_MS:   beep_half_ms_reg   <= cfg_data[MS_WIDTH-1:0];
                CFG_MOTION_HOLD_MS: motion_hold_ms_reg <= cfg_data[MS_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input register: hold the word until the pass can run
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg       <= s_tuser;
            rf_code_reg    <= s_tdata[31:0];
            rf_enabled_reg <= s_tdata[32];
            accel_x_reg    <= s_tdata[48:33];
            accel_y_reg    <= s_tdata[64:49];
            accel_z_reg    <= s_tdata[80:65];
        end
    end

    // ---------------------------------------------------------------
    // event decode and shared conditions
    // ---------------------------------------------------------------
    logic                  is_tick, is_rf, is_accel;
    time_t                 now_inc;
    time_t                 since_stage, since_toggle, since_motion;
    logic                  warn_running, beep_due, hold_expired;
    logic [SQ_WIDTH-1:0]   mag_sq;
    logic                  sample_moving;
    logic                  rf_live, owner_hit, net_hit, clear_hit;
    logic                  tick_warn, toggle_ev, escalate, warn_end_home, owner_drop;
    logic                  motion_rise, warn_start, motion_fall;

    assign is_tick  = (func_reg == FUNC_TICK);
    assign is_rf    = (func_reg == FUNC_RF);
    assign is_accel = (func_reg == FUNC_ACCEL);

    // tick logic looks at the advanced clock, samples at the current one
    assign now_inc      = now_reg + time_t'(1);
    assign since_stage  = now_inc - stage_start_reg;
    assign since_toggle = now_inc - last_toggle_reg;
    assign since_motion = now_reg - motion_start_reg;

    assign warn_running = since_stage < time_t'(warning_ms_reg);
    assign beep_due     = since_toggle >= time_t'(beep_half_ms_reg);
    assign hold_expired = since_motion > time_t'(motion_hold_ms_reg);

    // the sum of three squares tops out at 3 * 2^30 and fits without carry
    assign mag_sq = sq_mag(accel_x_reg) + sq_mag(accel_y_reg) + sq_mag(accel_z_reg);
    assign sample_moving = (mag_sq < still_low_sq_reg) || (mag_sq > still_high_sq_reg);

    // codes match in priority order owner, network, clear
    assign rf_live   = is_rf && rf_enabled_reg;
    assign owner_hit = rf_live && (rf_code_reg == owner_code_reg);
    assign net_hit   = rf_live && !owner_hit && (rf_code_reg == network_code_reg);
    assign clear_hit = rf_live && !owner_hit && !net_hit && (rf_code_reg == clear_code_reg);

    assign tick_warn     = is_tick && (stage_reg == ST_WARN);
    assign toggle_ev     = tick_warn && warn_running && beep_due;
    assign escalate      = tick_warn && !warn_running && !owner_reg;
    assign warn_end_home = tick_warn && !warn_running && owner_reg;
    assign owner_drop    = owner_hit && !owner_reg &&
                           ((stage_reg == ST_WARN) || (stage_reg == ST_ALERT));

    assign motion_rise = is_accel && sample_moving && !motion_reg;
    assign warn_start  = motion_rise && !owner_reg && (stage_reg == ST_IDLE);
    assign motion_fall = is_accel && !sample_moving && motion_reg && hold_expired;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        now_next          = now_reg;
        stage_start_next  = stage_start_reg;
        last_toggle_next  = last_toggle_reg;
        motion_start_next = motion_start_reg;
        stage_next        = stage_reg;
        buzzer_next       = buzzer_reg;
        owner_next        = owner_reg;
        motion_next       = motion_reg;

        if (is_tick)
        begin
            now_next = now_inc;
        end
        if (toggle_ev)
        begin
            buzzer_next      = !buzzer_reg;
            last_toggle_next = now_inc;
        end
        if (escalate)
        begin
            stage_next       = ST_ALERT;
            stage_start_next = now_inc;
            buzzer_next      = 1'b0;
        end
        if (warn_end_home || owner_drop || clear_hit)
        begin
            stage_next  = ST_IDLE;
            buzzer_next = 1'b0;
        end
        if (owner_hit)
        begin
            owner_next = 1'b1;
        end
        if (clear_hit)
        begin
            owner_next = 1'b0;
        end
        if (motion_rise)
        begin
            motion_next       = 1'b1;
            motion_start_next = now_reg;
        end
        if (warn_start)
        begin
            stage_next       = ST_WARN;
            stage_start_next = now_reg;
        end
        if (motion_fall)
        begin
            motion_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // result word: levels after the event plus the one-shot requests
    // ---------------------------------------------------------------
    always_comb
    begin
        out_data_next      = '0;
        out_data_next[1:0] = stage_next;
        out_data_next[2]   = buzzer_next;
        out_data_next[3]   = owner_next;
        out_data_next[4]   = motion_next;
        out_data_next[5]   = net_hit;
        out_data_next[6]   = escalate;
        out_data_next[7]   = owner_drop || clear_hit;
        out_data_next[8]   = escalate;
    end

    // advance state and load the result only when the pass fires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg          <= '0;
            stage_start_reg  <= '0;
            last_toggle_reg  <= '0;
            motion_start_reg <= '0;
            stage_reg        <= ST_IDLE;
            buzzer_reg       <= 1'b0;
            owner_reg        <= 1'b0;
            motion_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                now_reg          <= now_next;
                stage_start_reg  <= stage_start_next;
                last_toggle_reg  <= last_toggle_next;
                motion_start_reg <= motion_start_next;
                stage_reg        <= stage_next;
                buzzer_reg       <= buzzer_next;
                owner_reg        <= owner_next;
                motion_reg       <= motion_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // input side stalls only behind a held result word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled while result slot free");

    // the GPS start request only comes with the alert stage
    a_gps_on_alert: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[6]) |-> (out_data_reg[1:0] == ST_ALERT))
        else $error("gps on request outside alert");

    // start and stop requests never share a word
    a_gps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg[6] && out_data_reg[7]))
        else $error("gps on and off in one word");

    // the tracking stage is never entered
    a_no_track: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg != ST_TRACK)
        else $error("tracking stage reached");

    // a fired pass leaves a valid result word in the cycle after
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("result word lost");

endmodule
